>>> rtl/spims_pkg.sv
// Shared types, register codes and reset constants for the SPI master word shifter.
package spims_pkg;

  // Default word length in bits.
  localparam int WORD_BITS_DEF = 8;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_POLARITY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_PHASE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LSB_FIRST         = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD_TICKS = 2'd3;

  localparam int CFG_DATA_W = 16;
  localparam logic [15:0] HALF_PERIOD_RST = 16'd4;

  // Input item modes.
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] tx_byte;
    logic       last_byte;
    logic       miso_level;
  } in_item_t;

  typedef struct packed {
    logic       sclk_level;
    logic       mosi_level;
    logic       select_n;
    logic       busy_res;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       load_rejected;
  } out_item_t;

  typedef struct packed {
    logic        clock_polarity;
    logic        clock_phase;
    logic        lsb_first;
    logic [15:0] half_period_ticks;
  } cfg_regs_t;

endpackage

>>> rtl/spims_cfg.sv
// Configuration register file for the SPI master word shifter.
module spims_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [spims_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [spims_pkg::CFG_DATA_W-1:0]   wr_data,
  output spims_pkg::cfg_regs_t               cfg
);

  spims_pkg::cfg_regs_t cfg_r;

  // Register writes; each register takes the low bits of the write data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clock_polarity    <= 1'b0;
      cfg_r.clock_phase       <= 1'b0;
      cfg_r.lsb_first         <= 1'b0;
      cfg_r.half_period_ticks <= spims_pkg::HALF_PERIOD_RST;
    end else if (wr_en) begin
      case (wr_index)
        spims_pkg::CFG_CLOCK_POLARITY:    cfg_r.clock_polarity    <= wr_data[0];
        spims_pkg::CFG_CLOCK_PHASE:       cfg_r.clock_phase       <= wr_data[0];
        spims_pkg::CFG_LSB_FIRST:         cfg_r.lsb_first         <= wr_data[0];
        spims_pkg::CFG_HALF_PERIOD_TICKS: cfg_r.half_period_ticks <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/spims_core.sv
// Shift state and single pass next state logic of the SPI master word shifter.
module spims_core #(
  parameter int WORD_BITS = spims_pkg::WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_fire,
  input  spims_pkg::in_item_t   item,
  input  spims_pkg::cfg_regs_t  cfg,
  output spims_pkg::out_item_t  result
);

  localparam int IDX_W = $clog2(WORD_BITS);
  localparam int CNT_W = $clog2(WORD_BITS + 1);
  localparam int WIDE_W = (WORD_BITS > 8) ? WORD_BITS : 8;

  logic [WORD_BITS-1:0] tx_shift_r, tx_shift_nxt;
  logic [WORD_BITS-1:0] rx_shift_r, rx_shift_nxt;
  logic [CNT_W-1:0]     bit_index_r, bit_index_nxt;
  logic                 edge_phase_r, edge_phase_nxt;
  logic [15:0]          tick_count_r, tick_count_nxt;
  logic                 clock_level_r, clock_level_nxt;
  logic                 data_out_r, data_out_nxt;
  logic                 select_r, select_nxt;
  logic                 shifting_r, shifting_nxt;
  logic                 release_r, release_nxt;

  logic [WIDE_W-1:0]    tx_wide;
  logic [WIDE_W-1:0]    rx_wide;
  logic [WORD_BITS-1:0] tx_load;
  logic [IDX_W-1:0]     pos_load;
  logic [IDX_W-1:0]     pos_cur;
  logic [IDX_W-1:0]     pos_inc;
  logic [CNT_W-1:0]     cnt_inc;
  logic [15:0]          half_period;
  logic [16:0]          tick_inc;
  logic                 word_done;
  logic                 rejected;

  // Bit positions for the first bit, the current bit and the following bit.
  assign tx_wide  = WIDE_W'(item.tx_byte);
  assign tx_load  = tx_wide[WORD_BITS-1:0];
  assign cnt_inc  = bit_index_r + 1'b1;
  assign pos_load = cfg.lsb_first ? '0 : IDX_W'(WORD_BITS - 1);
  assign pos_cur  = cfg.lsb_first ? bit_index_r[IDX_W-1:0]
                                  : IDX_W'(WORD_BITS - 1) - bit_index_r[IDX_W-1:0];
  assign pos_inc  = cfg.lsb_first ? cnt_inc[IDX_W-1:0]
                                  : IDX_W'(WORD_BITS - 1) - cnt_inc[IDX_W-1:0];
  assign half_period = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
  assign tick_inc    = {1'b0, tick_count_r} + 17'd1;

  // Next state for one item: a load, a tick between edges, or a clock edge.
  // A sampled bit is ORed in, so a position sampled twice after a mid-word
  // register change keeps any one that was seen.
  always_comb begin
    tx_shift_nxt    = tx_shift_r;
    rx_shift_nxt    = rx_shift_r;
    bit_index_nxt   = bit_index_r;
    edge_phase_nxt  = edge_phase_r;
    tick_count_nxt  = tick_count_r;
    clock_level_nxt = clock_level_r;
    data_out_nxt    = data_out_r;
    select_nxt      = select_r;
    shifting_nxt    = shifting_r;
    release_nxt     = release_r;
    word_done       = 1'b0;
    rejected        = 1'b0;

    if (item.mode == spims_pkg::MODE_LOAD) begin
      if (shifting_r) begin
        rejected = 1'b1;
      end else begin
        shifting_nxt    = 1'b1;
        select_nxt      = 1'b0;
        clock_level_nxt = cfg.clock_polarity;
        tx_shift_nxt    = tx_load;
        rx_shift_nxt    = '0;
        bit_index_nxt   = '0;
        edge_phase_nxt  = 1'b0;
        tick_count_nxt  = '0;
        release_nxt     = item.last_byte;
        if (!cfg.clock_phase) begin
          data_out_nxt = tx_load[pos_load];
        end
      end
    end else if (shifting_r) begin
      if (tick_inc < {1'b0, half_period}) begin
        tick_count_nxt = tick_inc[15:0];
      end else begin
        tick_count_nxt  = '0;
        clock_level_nxt = ~clock_level_r;
        if (!edge_phase_r) begin
          // Leading edge.
          if (!cfg.clock_phase) begin
            rx_shift_nxt[pos_cur] = rx_shift_r[pos_cur] | item.miso_level;
          end else begin
            data_out_nxt = tx_shift_r[pos_cur];
          end
          edge_phase_nxt = 1'b1;
        end else begin
          // Trailing edge, which closes the bit.
          if (cfg.clock_phase) begin
            rx_shift_nxt[pos_cur] = rx_shift_r[pos_cur] | item.miso_level;
          end
          edge_phase_nxt = 1'b0;
          bit_index_nxt  = cnt_inc;
          if (cnt_inc == CNT_W'(WORD_BITS)) begin
            word_done = 1'b1;
          end else if (!cfg.clock_phase) begin
            data_out_nxt = tx_shift_r[pos_inc];
          end
        end
        if (word_done) begin
          shifting_nxt  = 1'b0;
          bit_index_nxt = '0;
          if (release_r) begin
            select_nxt = 1'b1;
          end
        end
      end
    end
  end

  // Result for this item, built from the next state.
  assign rx_wide = WIDE_W'(rx_shift_nxt);
  always_comb begin
    result.sclk_level    = clock_level_nxt;
    result.mosi_level    = data_out_nxt;
    result.select_n      = select_nxt;
    result.busy_res      = shifting_nxt;
    result.rx_valid      = word_done;
    result.rx_byte       = word_done ? rx_wide[7:0] : 8'd0;
    result.load_rejected = rejected;
  end

  // Shift state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_shift_r    <= '0;
      rx_shift_r    <= '0;
      bit_index_r   <= '0;
      edge_phase_r  <= 1'b0;
      tick_count_r  <= '0;
      clock_level_r <= 1'b0;
      data_out_r    <= 1'b0;
      select_r      <= 1'b1;
      shifting_r    <= 1'b0;
      release_r     <= 1'b0;
    end else if (item_fire) begin
      tx_shift_r    <= tx_shift_nxt;
      rx_shift_r    <= rx_shift_nxt;
      bit_index_r   <= bit_index_nxt;
      edge_phase_r  <= edge_phase_nxt;
      tick_count_r  <= tick_count_nxt;
      clock_level_r <= clock_level_nxt;
      data_out_r    <= data_out_nxt;
      select_r      <= select_nxt;
      shifting_r    <= shifting_nxt;
      release_r     <= release_nxt;
    end
  end

  // Chip select stays asserted for the whole word.
  a_select_while_shifting: assert property (@(posedge clk) disable iff (!rst_n)
    shifting_r |-> !select_r)
    else $error("chip select released while a word is shifting");

  // Idle means the bit and tick counters are back at zero.
  a_idle_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !shifting_r |-> (bit_index_r == '0) && (tick_count_r == '0) && !edge_phase_r)
    else $error("bit or tick counter left nonzero while idle");

  // The bit counter never reaches the word length between items.
  a_bit_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_index_r < CNT_W'(WORD_BITS))
    else $error("bit counter out of range");

endmodule

>>> rtl/spi_master_byte_shifter_unit.sv
// Top level of the SPI master word shifter: input register, shift logic, result register.
// A transfer accepted into the input register passes the shift logic and is held in the
// result register. Throughput: one item per cycle unless a held result stalls the pipeline,
// set by the single pass next state logic between the two registers.
// Configuration writes are registered and take effect in the cycle after their transfer.
// Synchronous active-low reset idles the shifter, deselects the slave and restores defaults.
module spi_master_byte_shifter_unit #(
  parameter int WORD_BITS = spims_pkg::WORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  spims_pkg::in_item_t               in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output spims_pkg::out_item_t              out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [spims_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spims_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                 in_vld_r;
  spims_pkg::in_item_t  in_data_r;
  logic                 out_vld_r;
  spims_pkg::out_item_t out_data_r;
  spims_pkg::out_item_t result;
  spims_pkg::cfg_regs_t cfg;
  logic                 advance;
  logic                 item_fire;

  // Pipeline moves whenever the result register is empty or being drained.
  assign advance   = !out_vld_r || out_ready;
  assign in_ready  = !in_vld_r || advance;
  assign item_fire = in_vld_r && advance;
  assign cfg_ready = 1'b1;

  spims_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  spims_core #(
    .WORD_BITS (WORD_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (item_fire),
    .item      (in_data_r),
    .cfg       (cfg),
    .result    (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // A completed word always reports the shifter as idle.
  a_rx_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_data_r.rx_valid) |-> !out_data_r.busy_res)
    else $error("word reported while still busy");

  // A rejected load is only possible while a word is shifting.
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_data_r.load_rejected) |-> out_data_r.busy_res && !out_data_r.rx_valid)
    else $error("load rejected while idle");

  // A held result does not let a new item into the shift logic.
  a_no_fire_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |-> !item_fire)
    else $error("item processed while result stalled");

endmodule
